// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/bdc_pkg.sv =====
// ---------------------------------------------------------------------------
// bdc_pkg
// Types, constants and calendar helpers for the business day counter.
// ---------------------------------------------------------------------------
package bdc_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 16;
    localparam int WDAY_W  = 3;
    localparam int MASK_W  = 7;

    localparam logic [MASK_W-1:0]  WEEKEND_RESET = 7'd96;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = 16'hFFFF;
    localparam logic [WDAY_W-1:0]  SATURDAY      = 3'd6;

    // Reciprocal constants: n / 100 == (n * 5243) >> 19 for n < 43690,
    // n / 7 == (n * 18725) >> 17 for n < 43690.
    localparam logic [12:0] DIV100_MUL = 13'd5243;
    localparam logic [14:0] DIV7_MUL   = 15'd18725;
    localparam logic [6:0]  CENTURY    = 7'd100;

    // Request queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // (31 * m) / 12 of the weekday formula, indexed by the raw month code,
    // with the January/February shift already folded in.
    localparam logic [5:0] MONTH_OFFSET [16] = '{
        6'd25, 6'd28, 6'd31, 6'd2,  6'd5,  6'd7,  6'd10, 6'd12,
        6'd15, 6'd18, 6'd20, 6'd23, 6'd25, 6'd28, 6'd31, 6'd33
    };

    // Year first so that a plain unsigned compare orders two dates.
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_date;

    typedef struct packed {
        logic [DAY_W-1:0]   start_day;
        logic [MONTH_W-1:0] start_month;
        logic [YEAR_W-1:0]  start_year;
        logic [DAY_W-1:0]   end_day;
        logic [MONTH_W-1:0] end_month;
        logic [YEAR_W-1:0]  end_year;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_W-1:0] business_days;
        logic               walk_limit_hit;
    } t_out_item;

    typedef struct packed {
        t_date start;
        t_date finish;
        logic  empty;
    } t_queue_entry;

    typedef struct packed {
        logic  valid;
        t_date date;
    } t_wday_req;

    typedef struct packed {
        logic              valid;
        logic [WDAY_W-1:0] weekday;
        logic              leap;
    } t_wday_rsp;

    typedef struct packed {
        logic idle;
        logic wday_wait;
    } t_back_status;

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
        logic [DAY_W-1:0] days;
        case (month)
            4'd2:                   days = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: days = 5'd30;
            default:                days = 5'd31;
        endcase
        return days;
    endfunction

endpackage

// ===== rtl/core/bdc_front.sv =====
// ---------------------------------------------------------------------------
// bdc_front
// Takes requests, compares the two dates and marks requests with nothing to walk.
// ---------------------------------------------------------------------------
module bdc_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  bdc_pkg::t_in_item      i_in_item,
    output logic                   o_push_valid,
    input  logic                   i_push_ready,
    output bdc_pkg::t_queue_entry  o_push_entry
);
    import bdc_pkg::*;

    logic         r_valid;
    t_queue_entry r_entry;
    t_date        start_date;
    t_date        finish_date;

    assign start_date  = '{year: i_in_item.start_year, month: i_in_item.start_month,
                           day: i_in_item.start_day};
    assign finish_date = '{year: i_in_item.end_year, month: i_in_item.end_month,
                           day: i_in_item.end_day};

    assign o_in_ready   = !r_valid || i_push_ready;
    assign o_push_valid = r_valid;
    assign o_push_entry = r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_entry.start  <= start_date;
            r_entry.finish <= finish_date;
            // A start on or after the end walks no day at all.
            r_entry.empty  <= !(start_date < finish_date);
        end
    end

endmodule

// ===== rtl/core/bdc_queue.sv =====
// ---------------------------------------------------------------------------
// bdc_queue
// Short first-in first-out queue of classified requests.
// ---------------------------------------------------------------------------
module bdc_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push_valid,
    output logic                   o_push_ready,
    input  bdc_pkg::t_queue_entry  i_push_entry,
    output logic                   o_pop_valid,
    input  logic                   i_pop_ready,
    output bdc_pkg::t_queue_entry  o_pop_entry
);
    import bdc_pkg::*;

    t_queue_entry      r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = r_count != QCNT_W'(QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_entry  = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] ptr);
        return (ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

endmodule

// ===== rtl/core/bdc_wday.sv =====
// ---------------------------------------------------------------------------
// bdc_wday
// Five-stage pipeline giving the weekday and leap flag of one date.
// ---------------------------------------------------------------------------
module bdc_wday (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bdc_pkg::t_wday_req  i_req,
    output bdc_pkg::t_wday_rsp  o_rsp
);
    import bdc_pkg::*;

    logic [4:0] r_valid;

    // Stage 0: month shift and year adjustment.
    logic [DAY_W-1:0]  r0_day;
    logic [YEAR_W-1:0] r0_yeff;
    logic [YEAR_W-1:0] r0_year;
    logic              r0_neg;
    logic [5:0]        r0_off;
    // Stage 1: year / 100.
    logic [DAY_W-1:0]  r1_day;
    logic [YEAR_W-1:0] r1_yeff;
    logic [YEAR_W-1:0] r1_year;
    logic              r1_neg;
    logic [5:0]        r1_off;
    logic [7:0]        r1_q100;
    // Stage 2: year / 400.
    logic [DAY_W-1:0]  r2_day;
    logic [YEAR_W-1:0] r2_yeff;
    logic [YEAR_W-1:0] r2_year;
    logic              r2_neg;
    logic [5:0]        r2_off;
    logic [7:0]        r2_q100;
    logic [5:0]        r2_q400;
    // Stage 3: weekday sum, and the century of the unshifted year.
    logic [14:0]       r3_sum;
    logic [YEAR_W-1:0] r3_year;
    logic [7:0]        r3_qraw;
    // Stage 4: results.
    logic [WDAY_W-1:0] r4_weekday;
    logic              r4_leap;

    logic              shift_year;
    logic [26:0]       prod100;
    logic [24:0]       prod400;
    logic [26:0]       prod_raw;
    logic [29:0]       prod7;
    logic [12:0]       q7;
    logic [14:0]       rem7;
    logic [14:0]       hundreds;

    // January and February, and the out-of-range month zero, count as
    // months of the year before. Year zero then goes to minus one, whose
    // truncated quotients are all zero.
    assign shift_year = i_req.date.month <= 4'd2;

    assign prod100  = 27'(r0_yeff) * 27'(DIV100_MUL);
    assign prod400  = 25'(r1_yeff[YEAR_W-1:2]) * 25'(DIV100_MUL);
    assign prod_raw = 27'(r2_year) * 27'(DIV100_MUL);
    assign prod7    = 30'(r3_sum) * 30'(DIV7_MUL);
    assign q7       = prod7[29:17];
    assign rem7     = r3_sum - (15'({q7, 3'b000}) - 15'(q7));
    assign hundreds = 15'(r3_qraw) * 15'(CENTURY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[3:0], i_req.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r0_day  <= i_req.date.day;
        r0_year <= i_req.date.year;
        r0_neg  <= shift_year && (i_req.date.year == '0);
        r0_yeff <= (shift_year && (i_req.date.year == '0)) ? '0 :
                   i_req.date.year - YEAR_W'(shift_year);
        r0_off  <= MONTH_OFFSET[i_req.date.month];

        r1_day  <= r0_day;
        r1_yeff <= r0_yeff;
        r1_year <= r0_year;
        r1_neg  <= r0_neg;
        r1_off  <= r0_off;
        r1_q100 <= prod100[26:19];

        r2_day  <= r1_day;
        r2_yeff <= r1_yeff;
        r2_year <= r1_year;
        r2_neg  <= r1_neg;
        r2_off  <= r1_off;
        r2_q100 <= r1_q100;
        r2_q400 <= prod400[24:19];

        r3_sum  <= 15'(r2_day) + 15'(r2_yeff) + 15'(r2_yeff[YEAR_W-1:2]) + 15'(r2_q400)
                 + 15'(r2_off) - 15'(r2_q100) - 15'(r2_neg);
        r3_year <= r2_year;
        r3_qraw <= prod_raw[26:19];

        r4_weekday <= rem7[WDAY_W-1:0];
        r4_leap    <= (r3_year[1:0] == 2'b00)
                   && ((15'(r3_year) != hundreds) || (r3_qraw[1:0] == 2'b00));
    end

    assign o_rsp.valid   = r_valid[4];
    assign o_rsp.weekday = r4_weekday;
    assign o_rsp.leap    = r4_leap;

endmodule

// ===== rtl/core/bdc_back.sv =====
// ---------------------------------------------------------------------------
// bdc_back
// Walks one day per cycle except during weekday lookups; counts business days.
// ---------------------------------------------------------------------------
module bdc_back #(
    parameter int MAX_WALK_DAYS = 65535
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_pop_valid,
    output logic                        o_pop_ready,
    input  bdc_pkg::t_queue_entry       i_pop_entry,
    input  logic [bdc_pkg::MASK_W-1:0]  i_weekend_mask,
    output bdc_pkg::t_wday_req          o_wday_req,
    input  bdc_pkg::t_wday_rsp          i_wday_rsp,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output bdc_pkg::t_out_item          o_out_item,
    output bdc_pkg::t_back_status       o_status
);
    import bdc_pkg::*;

    localparam int STEP_W = $clog2(MAX_WALK_DAYS + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_WDAY = 4'b0010,
        ST_WALK = 4'b0100,
        ST_DONE = 4'b1000
    } t_back_state;

    t_back_state       r_state,     n_state;
    logic              r_wday_req,  n_wday_req;
    logic              r_out_valid, n_out_valid;
    t_date             r_cursor,    n_cursor;
    t_date             r_end,       n_end;
    logic [WDAY_W-1:0] r_weekday,   n_weekday;
    logic              r_leap,      n_leap;
    logic [COUNT_W-1:0] r_tally,    n_tally;
    logic [STEP_W-1:0] r_steps,     n_steps;
    logic              r_hit,       n_hit;
    t_out_item         r_out,       n_out;

    logic [DAY_W-1:0]  day_len;
    logic              rollover;
    t_date             next_date;

    assign day_len  = month_days(r_cursor.month, r_leap);
    // A day at or past the month length counts as its last day.
    assign rollover = r_cursor.day >= day_len;

    always_comb begin
        next_date = r_cursor;
        if (rollover) begin
            next_date.day = DAY_W'(1);
            if (r_cursor.month >= 4'd12) begin
                next_date.month = MONTH_W'(1);
                next_date.year  = r_cursor.year + 1'b1;
            end else begin
                next_date.month = r_cursor.month + 1'b1;
            end
        end else begin
            next_date.day = r_cursor.day + 1'b1;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_wday_req  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        n_cursor    = r_cursor;
        n_end       = r_end;
        n_weekday   = r_weekday;
        n_leap      = r_leap;
        n_tally     = r_tally;
        n_steps     = r_steps;
        n_hit       = r_hit;
        n_out       = r_out;
        case (r_state)
            ST_IDLE: begin
                if (i_pop_valid) begin
                    n_cursor = i_pop_entry.start;
                    n_end    = i_pop_entry.finish;
                    n_tally  = '0;
                    n_steps  = '0;
                    n_hit    = 1'b0;
                    if (i_pop_entry.empty) begin
                        n_state = ST_DONE;
                    end else begin
                        n_wday_req = 1'b1;
                        n_state    = ST_WDAY;
                    end
                end
            end
            ST_WDAY: begin
                if (i_wday_rsp.valid) begin
                    n_weekday = i_wday_rsp.weekday;
                    n_leap    = i_wday_rsp.leap;
                    n_state   = ST_WALK;
                end
            end
            ST_WALK: begin
                if (!(r_cursor < r_end)) begin
                    n_state = ST_DONE;
                end else if (r_steps == STEP_W'(MAX_WALK_DAYS)) begin
                    n_hit   = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    if (!i_weekend_mask[r_weekday] && (r_tally != COUNT_MAX)) begin
                        n_tally = r_tally + 1'b1;
                    end
                    n_steps  = r_steps + 1'b1;
                    n_cursor = next_date;
                    // Inside a month only the day term of the weekday moves;
                    // a new month goes back through the weekday pipeline.
                    if (rollover) begin
                        n_wday_req = 1'b1;
                        n_state    = ST_WDAY;
                    end else begin
                        n_weekday = (r_weekday == SATURDAY) ? '0 : r_weekday + 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.business_days  = r_tally;
                    n_out.walk_limit_hit = r_hit;
                    n_out_valid          = 1'b1;
                    n_state              = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wday_req  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wday_req  <= n_wday_req;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cursor  <= n_cursor;
        r_end     <= n_end;
        r_weekday <= n_weekday;
        r_leap    <= n_leap;
        r_tally   <= n_tally;
        r_steps   <= n_steps;
        r_hit     <= n_hit;
        r_out     <= n_out;
    end

    assign o_pop_ready        = r_state == ST_IDLE;
    assign o_wday_req.valid   = r_wday_req;
    assign o_wday_req.date    = r_cursor;
    assign o_out_valid        = r_out_valid;
    assign o_out_item         = r_out;
    assign o_status.idle      = r_state == ST_IDLE;
    assign o_status.wday_wait = r_state == ST_WDAY;

endmodule

// ===== rtl/core/business_day_counter.sv =====
// ---------------------------------------------------------------------------
// business_day_counter
// Counts the business days from a start date up to, not including, an end date.
// ---------------------------------------------------------------------------
// Each request carries two Gregorian dates; the result is the number of days
// in the half-open range whose weekday is not marked in the weekend mask
// (bit 0 Sunday, reset value Friday and Saturday), with a flag raised when
// the walk stops after MAX_WALK_DAYS days. The walker covers one calendar day
// per clock cycle, except while it waits on the weekday pipeline, which it asks
// at the start of each walk and at every month boundary; a request whose start
// is not before the end skips the walk. Requests queue in front of the walker,
// so new ones are taken while a walk runs or a result waits. The weekend mask
// is written through its own port; the user must write it only while no request
// is in flight, since the block itself does not enforce this.
`include "assert_macros.svh"

module business_day_counter #(
    parameter int MAX_WALK_DAYS = 65535
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  bdc_pkg::t_in_item           i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output bdc_pkg::t_out_item          o_out_item,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [bdc_pkg::MASK_W-1:0]  i_cfg_data
);
    import bdc_pkg::*;

    logic [MASK_W-1:0] r_weekend_mask;
    logic              push_valid;
    logic              push_ready;
    t_queue_entry      push_entry;
    logic              pop_valid;
    logic              pop_ready;
    t_queue_entry      pop_entry;
    t_wday_req         wday_req;
    t_wday_rsp         wday_rsp;
    t_back_status      back_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weekend_mask <= WEEKEND_RESET;
        end else if (i_cfg_valid) begin
            r_weekend_mask <= i_cfg_data;
        end
    end

    bdc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_entry (push_entry)
    );

    bdc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_entry (push_entry),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_entry  (pop_entry)
    );

    bdc_wday u_wday (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (wday_req),
        .o_rsp   (wday_rsp)
    );

    bdc_back #(
        .MAX_WALK_DAYS (MAX_WALK_DAYS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pop_valid    (pop_valid),
        .o_pop_ready    (pop_ready),
        .i_pop_entry    (pop_entry),
        .i_weekend_mask (r_weekend_mask),
        .o_wday_req     (wday_req),
        .i_wday_rsp     (wday_rsp),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_item     (o_out_item),
        .o_status       (back_status)
    );

    // A weekday answer must find the walker waiting for it.
    `ASSERT_SAME(a_wday_rsp_expected, wday_rsp.valid, back_status.wday_wait)
    // The walker never has two weekday lookups in flight.
    `ASSERT_NEXT(a_wday_req_single, wday_req.valid, !wday_req.valid && back_status.wday_wait)
    // A request leaves the queue only when the walker is free.
    `ASSERT_SAME(a_pop_when_idle, pop_valid && pop_ready, back_status.idle)
    // The count cannot exceed the walk limit MAX_WALK_DAYS.
    `ASSERT_SAME(a_count_bounded, o_out_valid, 32'(o_out_item.business_days) <= 32'(MAX_WALK_DAYS))

endmodule

// ===== bench/tb_business_day_counter.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_business_day_counter
// Self-checking bench for the business day counter.
// ---------------------------------------------------------------------------
// Date ranges are queued by the stimulus process and presented by a clocked
// driver. The expected count is worked out when the block takes each request.
// A clocked monitor compares every result with the oldest expected one.
// The weekend mask is changed between phases while the block is idle. The
// stimulus covers leap years, odd months and days, year wrap and the walk
// limit, and then random ranges with random gaps on both sides.
// ---------------------------------------------------------------------------
module tb_business_day_counter;

    import bdc_pkg::t_in_item;
    import bdc_pkg::t_out_item;

    localparam int unsigned WALK_LIMIT  = 65535;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int unsigned TAIL_CYCLES = 50;

    // Year first, so that an unsigned compare orders two dates.
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } t_cal_date;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    t_in_item   i_in_item   = '0;
    logic       i_out_ready = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic [6:0] i_cfg_data  = '0;
    logic       o_in_ready;
    logic       o_out_valid;
    t_out_item  o_out_item;
    logic       o_cfg_ready;

    business_day_counter #(
        .MAX_WALK_DAYS(WALK_LIMIT)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor copy of the weekend register.
    logic [6:0]  weekend_days = bdc_pkg::WEEKEND_RESET;

    t_in_item    pending_requests[$];
    t_out_item   due_results[$];

    int unsigned idle_odds     = 0;
    int unsigned gap_left      = 0;
    int unsigned stall_left    = 0;
    int unsigned accepted_reqs = 0;
    int unsigned limit_walks   = 0;
    int unsigned masks_written = 0;
    int unsigned fail_count    = 0;
    int unsigned cycle_count   = 0;

    function automatic bit is_leap(input logic [13:0] y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    // Month codes outside 1..12 are treated as 31-day months.
    function automatic int unsigned month_len(input logic [3:0] m, input logic [13:0] y);
        if (m < 1 || m > 12) return 31;
        if (m == 2) return is_leap(y) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
        return 31;
    endfunction

    // Signed arithmetic with truncating division, so odd dates may give a
    // negative remainder, which is folded back into 0..6.
    function automatic logic [2:0] weekday_of_date(input t_cal_date c);
        int dd, mo, a, y, m, w;
        dd = c.day;
        mo = c.month;
        a = (14 - mo) / 12;
        y = int'(c.year) - a;
        m = mo + 12 * a - 2;
        w = (dd + y + y / 4 - y / 100 + y / 400 + (31 * m) / 12) % 7;
        if (w < 0) w += 7;
        return w[2:0];
    endfunction

    // A day at or past the month length behaves as the last day; the year wraps.
    function automatic t_cal_date next_date(input t_cal_date c);
        t_cal_date n;
        n = c;
        if (c.day >= month_len(c.month, c.year)) begin
            n.day = 5'd1;
            if (c.month >= 12) begin
                n.month = 4'd1;
                n.year  = c.year + 14'd1;
            end else begin
                n.month = c.month + 4'd1;
            end
        end else begin
            n.day = c.day + 5'd1;
        end
        return n;
    endfunction

    function automatic t_cal_date date_after(input t_cal_date origin, input int unsigned n);
        t_cal_date d;
        d = origin;
        repeat (n) d = next_date(d);
        return d;
    endfunction

    function automatic t_cal_date date_of(input int unsigned d, input int unsigned m,
                                          input int unsigned y);
        t_cal_date c;
        c.day   = 5'(d);
        c.month = 4'(m);
        c.year  = 14'(y);
        return c;
    endfunction

    function automatic t_out_item count_business_days(input t_in_item req);
        t_cal_date   cur, stop;
        int unsigned steps, tally;
        logic        hit;
        t_out_item   res;
        cur   = '{year: req.start_year, month: req.start_month, day: req.start_day};
        stop  = '{year: req.end_year, month: req.end_month, day: req.end_day};
        steps = 0;
        tally = 0;
        hit   = 1'b0;
        while (!hit && cur < stop) begin
            if (steps >= WALK_LIMIT) begin
                hit = 1'b1;
            end else begin
                if (!weekend_days[weekday_of_date(cur)] && tally < bdc_pkg::COUNT_MAX)
                    tally++;
                cur = next_date(cur);
                steps++;
            end
        end
        if (hit) limit_walks++;
        res.business_days  = 16'(tally);
        res.walk_limit_hit = hit;
        return res;
    endfunction

    function automatic void queue_range(input t_cal_date s, input t_cal_date e);
        t_in_item req;
        req.start_day   = s.day;
        req.start_month = s.month;
        req.start_year  = s.year;
        req.end_day     = e.day;
        req.end_month   = e.month;
        req.end_year    = e.year;
        pending_requests.push_back(req);
    endfunction

    // Mostly proper dates a random span apart, some reversed, and the rest
    // raw field values with the end year at most one above the start, so walks stay short.
    function automatic void queue_random_ranges(input int unsigned n);
        t_cal_date   s, e;
        int unsigned kind;
        repeat (n) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                s.year  = ($urandom_range(0, 7) == 0) ? 14'($urandom_range(0, 16383))
                                                      : 14'($urandom_range(1, 9999));
                s.month = 4'($urandom_range(1, 12));
                s.day   = 5'($urandom_range(1, month_len(s.month, s.year)));
                e = date_after(s, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1200)
                                                              : $urandom_range(0, 60));
                if (kind == 6) queue_range(e, s);
                else queue_range(s, e);
            end else begin
                s = '{year: 14'($urandom_range(0, 16383)), month: 4'($urandom),
                      day: 5'($urandom)};
                e = '{year: s.year + 14'($urandom_range(0, 1)), month: 4'($urandom),
                      day: 5'($urandom)};
                queue_range(s, e);
            end
        end
    endfunction

    task automatic wait_until_idle();
        while (pending_requests.size() != 0 || i_in_valid || due_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_weekend_mask(input logic [6:0] mask);
        wait_until_idle();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mask;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid  <= 1'b0;
        weekend_days = mask;
        masks_written++;
    endtask

    // Request driver: holds each request until taken, with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left = 0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid) begin
                due_results.push_back(count_business_days(i_in_item));
                accepted_reqs++;
            end
            if (gap_left != 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_requests.size() != 0 && idle_odds != 0 &&
                         $urandom_range(1, idle_odds) == 1) begin
                gap_left = $urandom_range(1, 18) - 1;
                i_in_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                i_in_valid <= 1'b1;
                i_in_item  <= pending_requests.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: result with no request outstanding: count %0d, flag %0b",
                             $time, o_out_item.business_days, o_out_item.walk_limit_hit);
                    fail_count++;
                end else begin
                    if (o_out_item.business_days != due_results[0].business_days) begin
                        $display("%0t: business_days expected %0d, actual %0d", $time,
                                 due_results[0].business_days, o_out_item.business_days);
                        fail_count++;
                    end
                    if (o_out_item.walk_limit_hit != due_results[0].walk_limit_hit) begin
                        $display("%0t: walk_limit_hit expected %0b, actual %0b", $time,
                                 due_results[0].walk_limit_hit, o_out_item.walk_limit_hit);
                        fail_count++;
                    end
                    void'(due_results.pop_front());
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                stall_left = $urandom_range(1, 18) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: run timed out after %0d cycles", $time, cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed ranges under the reset weekend of Friday and Saturday.
        idle_odds = 4;
        queue_range(date_of(1, 1, 2024), date_of(31, 1, 2024));
        queue_range(date_of(15, 6, 2023), date_of(15, 6, 2023));
        queue_range(date_of(1, 1, 2024), date_of(1, 1, 2023));
        queue_range(date_of(31, 15, 16383), date_of(31, 15, 16383));
        queue_range(date_of(0, 0, 0), date_of(1, 0, 0));
        queue_range(date_of(28, 2, 2024), date_of(2, 3, 2024));
        queue_range(date_of(28, 2, 1900), date_of(2, 3, 1900));
        queue_range(date_of(28, 2, 2000), date_of(2, 3, 2000));
        queue_range(date_of(1, 13, 2023), date_of(1, 2, 2024));
        queue_range(date_of(1, 0, 2023), date_of(1, 3, 2023));
        queue_range(date_of(20, 15, 2023), date_of(5, 1, 2024));
        queue_range(date_of(31, 4, 2023), date_of(3, 5, 2023));
        queue_range(date_of(30, 2, 2023), date_of(2, 3, 2023));
        queue_range(date_of(0, 5, 2023), date_of(3, 5, 2023));
        queue_range(date_of(1, 1, 0), date_of(1, 3, 0));
        queue_range(date_of(30, 12, 2023), date_of(3, 1, 2024));
        queue_range(date_of(1, 1, 1), date_of(8, 1, 1));
        queue_range(date_of(1, 12, 16383), date_of(31, 12, 16383));
        // The year wraps to 0, so the end is never reached.
        queue_range(date_of(31, 12, 16383), date_of(1, 13, 16383));
        // One walk exactly at the limit and one a day beyond it.
        queue_range(date_of(1, 1, 2000), date_after(date_of(1, 1, 2000), WALK_LIMIT));
        queue_range(date_of(1, 1, 2000), date_after(date_of(1, 1, 2000), WALK_LIMIT + 1));
        wait_until_idle();

        queue_random_ranges(15);
        write_weekend_mask(7'h00);
        idle_odds = 0;
        queue_random_ranges(16);
        write_weekend_mask(7'h7F);
        idle_odds = 3;
        queue_random_ranges(12);
        write_weekend_mask(7'($urandom));
        idle_odds = 6;
        queue_random_ranges(17);
        write_weekend_mask(7'h41);
        idle_odds = 2;
        queue_random_ranges(17);
        write_weekend_mask(7'h01);
        idle_odds = 0;
        queue_random_ranges(20);

        wait_until_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Checked %0d date ranges under %0d weekend masks, %0d of them cut short",
                 accepted_reqs, masks_written + 1, limit_walks);
        $display("by the walk limit; %0d mismatches.", fail_count);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
